// ===== hdl/eta_pkg.sv =====
// Package: widths, codes, payload and control structs for edge_topic_argmax.
`timescale 1ns / 1ps

package eta_pkg;

   localparam int MAX_NODES  = 1024;
   localparam int NUM_TOPICS = 16;
   localparam int NODE_W     = 10;
   localparam int TOPIC_W    = 4;
   localparam int PROP_W     = 16;
   localparam int WEIGHT_W   = 32;
   localparam int PROD_W     = 2 * PROP_W;
   localparam int ADDR_W     = NODE_W + TOPIC_W;
   localparam int MEM_DEPTH  = MAX_NODES * NUM_TOPICS;

   localparam logic [TOPIC_W-1:0] TOPIC_FIRST = '0;
   localparam logic [TOPIC_W-1:0] TOPIC_LAST  = TOPIC_W'(NUM_TOPICS - 1);

   // request kinds
   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_EDGE = 1'b1;

   typedef struct packed {
      logic                req_type;
      logic [NODE_W-1:0]   row_node;
      logic [NODE_W-1:0]   col_node;
      logic [TOPIC_W-1:0]  topic_index;
      logic [PROP_W-1:0]   propensity;
      logic [WEIGHT_W-1:0] edge_weight;
   } eta_req_type;

   typedef struct packed {
      logic [NODE_W-1:0]   out_row;
      logic [NODE_W-1:0]   out_col;
      logic [TOPIC_W-1:0]  out_topic;
      logic [WEIGHT_W-1:0] out_weight;
   } eta_rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic               load_write;  // store the request's propensity entry
      logic               capture;     // latch the edge's nodes and weight
      logic               issue;       // read both nodes' entries for issue_topic
      logic [TOPIC_W-1:0] issue_topic;
      logic               load_out;    // move the winner into the output register
   } eta_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic edge_kept;     // presented request is an edge above the cutoff
      logic last_product;  // final topic's product is being compared
   } eta_status_type;

endpackage

// ===== hdl/eta_ram.sv =====
// Generic single-write, dual-read RAM with registered read data.
`timescale 1ns / 1ps

module eta_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_ff[rd_addr_a];
      rd_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// ===== hdl/eta_datapath.sv =====
// Datapath: propensity store, per-topic multiply, running argmax, output register.
`timescale 1ns / 1ps

module eta_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  eta_pkg::eta_req_type          req_item,
   input  logic                          csr_wr_en,
   input  logic [eta_pkg::WEIGHT_W-1:0]  csr_wr_data,
   input  eta_pkg::eta_cmd_type          cmd,
   output eta_pkg::eta_status_type       status,
   output eta_pkg::eta_rsp_type          rsp_item
);
   import eta_pkg::*;

   logic [WEIGHT_W-1:0] cutoff_ff, cutoff_in;
   logic [NODE_W-1:0]   row_ff, col_ff;
   logic [WEIGHT_W-1:0] weight_ff;

   logic [ADDR_W-1:0]   wr_addr, rd_addr_a, rd_addr_b;
   logic [PROP_W-1:0]   rd_data_a, rd_data_b;

   logic                s1_valid_ff, s1_valid_in;
   logic [TOPIC_W-1:0]  s1_topic_ff;
   logic                prod_valid_ff, prod_valid_in;
   logic [TOPIC_W-1:0]  prod_topic_ff;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [PROD_W-1:0]   best_prod_ff;
   logic [TOPIC_W-1:0]  best_topic_ff;
   logic                take;
   eta_rsp_type         rsp_ff;

   assign cutoff_in = csr_wr_en ? csr_wr_data : cutoff_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cutoff_ff     <= '0;
         s1_valid_ff   <= 1'b0;
         prod_valid_ff <= 1'b0;
      end else begin
         cutoff_ff     <= cutoff_in;
         s1_valid_ff   <= s1_valid_in;
         prod_valid_ff <= prod_valid_in;
      end
   end

   assign wr_addr   = {req_item.row_node, req_item.topic_index};
   assign rd_addr_a = {row_ff, cmd.issue_topic};
   assign rd_addr_b = {col_ff, cmd.issue_topic};

   eta_ram #(
      .WIDTH (PROP_W),
      .DEPTH (MEM_DEPTH)
   ) u_store (
      .clock     (clock),
      .wr_en     (cmd.load_write),
      .wr_addr   (wr_addr),
      .wr_data   (req_item.propensity),
      .rd_addr_a (rd_addr_a),
      .rd_data_a (rd_data_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_b (rd_data_b)
   );

   assign s1_valid_in   = cmd.issue;
   assign prod_valid_in = s1_valid_ff;
   assign prod_in       = PROD_W'(rd_data_a) * PROD_W'(rd_data_b);

   // topic 0 seeds the search; later topics win only when strictly larger
   assign take = prod_valid_ff && ((prod_topic_ff == TOPIC_FIRST) || (prod_ff > best_prod_ff));

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         row_ff    <= req_item.row_node;
         col_ff    <= req_item.col_node;
         weight_ff <= req_item.edge_weight;
      end
      s1_topic_ff   <= cmd.issue_topic;
      prod_topic_ff <= s1_topic_ff;
      prod_ff       <= prod_in;
      if (take) begin
         best_prod_ff  <= prod_ff;
         best_topic_ff <= prod_topic_ff;
      end
      if (cmd.load_out) begin
         rsp_ff.out_row    <= row_ff;
         rsp_ff.out_col    <= col_ff;
         rsp_ff.out_topic  <= best_topic_ff;
         rsp_ff.out_weight <= weight_ff;
      end
   end

   assign status.edge_kept    = (req_item.req_type == REQ_EDGE) &&
                                (req_item.edge_weight > cutoff_ff);
   assign status.last_product = prod_valid_ff && (prod_topic_ff == TOPIC_LAST);
   assign rsp_item            = rsp_ff;

endmodule

// ===== hdl/eta_ctrl.sv =====
// Controller: request sequencing, topic counter and result valid.
`timescale 1ns / 1ps

module eta_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_is_load,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output eta_pkg::eta_cmd_type    cmd,
   input  eta_pkg::eta_status_type status
);
   import eta_pkg::*;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_ISSUE  = 2'd1;
   localparam logic [1:0] ST_WAIT   = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0]         state_ff, state_in;
   logic [TOPIC_W-1:0] topic_ff, topic_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               out_blocked;
   logic               accept;

   assign out_blocked = rsp_valid_ff && rsp_stall;
   assign accept      = req_valid && (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      topic_in = topic_ff;
      cmd      = '0;
      cmd.issue_topic = topic_ff;
      unique case (state_ff)
         ST_IDLE: begin
            topic_in = TOPIC_FIRST;
            if (accept) begin
               if (req_is_load) begin
                  cmd.load_write = 1'b1;
               end else if (status.edge_kept) begin
                  cmd.capture = 1'b1;
                  state_in    = ST_ISSUE;
               end
            end
         end
         ST_ISSUE: begin
            cmd.issue = 1'b1;
            topic_in  = topic_ff + 1'b1;
            if (topic_ff == TOPIC_LAST) begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (status.last_product) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!out_blocked) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid_in = cmd.load_out || out_blocked;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         topic_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         topic_ff     <= topic_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // the last product only shows up while waiting for the pipeline to drain
   a_last_in_wait: assert property (@(posedge clock) disable iff (reset)
      status.last_product |-> state_ff == ST_WAIT)
      else $error("last product outside drain wait");

   // issuing the last topic always moves on to the drain wait
   a_issue_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ISSUE && topic_ff == TOPIC_LAST) |=> state_ff == ST_WAIT)
      else $error("issue phase did not end after last topic");

   // a stalled result is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> !out_blocked)
      else $error("output register overwritten while stalled");

   // a new result appears only out of the finish state
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_FINISH)
      else $error("result raised outside finish");

endmodule

// ===== hdl/edge_topic_argmax.sv =====
// Top level of edge_topic_argmax: per-edge best-topic classifier.
`timescale 1ns / 1ps

// Usage
//   req channel (req_valid / req_stall / req_item): a load request writes one
//   Q8.8 propensity at (row_node, topic_index); an edge request brings two
//   nodes and a Q16.16 weight. Edges at or below the cutoff are dropped.
//   rsp channel (rsp_valid / rsp_stall / rsp_item): one response per kept
//   edge carrying row, column, weight and the topic whose propensity product
//   is largest (lowest topic on ties).
//   csr port: csr_wr_en writes csr_wr_data into the weight cutoff; the user
//   must write it only while the block is idle; the block does not enforce it.
// Sequence
//   Loads and dropped edges are taken back to back while the block is idle.
//   A kept edge is accepted, then every topic is issued, one per cycle, to
//   the two read ports of the propensity store; the read/multiply stages
//   drain and the winner moves into the output register. The request side
//   stalls meanwhile: the dual-port store does one multiply-compare per topic.
// Reset clears the control state and the cutoff; the store is not cleared,
//   so entries must be loaded before an edge reads them.
// A stalled response holds in the output register; the block still takes
//   the next request and computes, and waits only to hand over a new result.
module edge_topic_argmax (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  eta_pkg::eta_req_type          req_item,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output eta_pkg::eta_rsp_type          rsp_item,
   input  logic                          csr_wr_en,
   input  logic [eta_pkg::WEIGHT_W-1:0]  csr_wr_data
);
   import eta_pkg::*;

   eta_cmd_type    cmd;
   eta_status_type status;
   logic           req_is_load;

   assign req_is_load = (req_item.req_type == REQ_LOAD);

   // sequencing: idle / issue topics / drain / hand over
   eta_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_is_load (req_is_load),
      .req_stall   (req_stall),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .cmd         (cmd),
      .status      (status)
   );

   // store, multiplier, argmax and output register
   eta_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_item    (req_item),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .status      (status),
      .rsp_item    (rsp_item)
   );

endmodule

// ===== tb/edge_topic_argmax_test.sv =====
// Self-checking testbench for edge_topic_argmax: table loads, edge classification, cutoff.
`timescale 1ns / 1ps

module edge_topic_argmax_test;
   import eta_pkg::*;

   // Quiet period long enough to cover one kept edge in flight.
   localparam int SETTLE_CYCLES  = 25;
   // Long receiver hold-off used to back the block up into its input.
   localparam int HOLD_CYCLES    = 400;
   // Cycles with no handshake on either channel before the run is declared hung.
   localparam int WATCHDOG_LIMIT = 2000;
   localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = '1;

   logic                clock       = 1'b0;
   logic                reset       = 1'b1;
   logic                req_valid   = 1'b0;
   logic                req_stall;
   eta_req_type         req_item    = '0;
   logic                rsp_valid;
   logic                rsp_stall   = 1'b0;
   eta_rsp_type         rsp_item;
   logic                csr_wr_en   = 1'b0;
   logic [WEIGHT_W-1:0] csr_wr_data = '0;

   edge_topic_argmax u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_item    (req_item),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_item    (rsp_item),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------
   // Shadow copy of the block: propensity table, which entries hold data,
   // and the cutoff. A node may appear in an edge only once all of its
   // topics were loaded, since the table powers up with garbage.
   // ---------------------------------------------------------------------
   logic [PROP_W-1:0]   prop_table     [MEM_DEPTH];
   bit                  entry_written  [MEM_DEPTH];
   int unsigned         node_fill      [MAX_NODES];
   int                  ready_nodes    [$];
   logic [WEIGHT_W-1:0] cutoff_mirror  = '0;
   eta_rsp_type         kept_edges_due [$];

   int fail_count    = 0;
   int load_count    = 0;
   int kept_count    = 0;
   int dropped_count = 0;
   int cutoff_writes = 0;

   // Stimulus knobs, percent per cycle.
   int send_idle_pct = 0;
   int stall_pct     = 0;
   // Bumped by a test to ask the stall process for one long hold-off.
   int hold_requests = 0;

   // Topic whose propensity product is largest; lowest topic wins a tie,
   // so only a strictly larger product moves the winner.
   function automatic logic [TOPIC_W-1:0] best_topic(input logic [NODE_W-1:0] a,
                                                     input logic [NODE_W-1:0] b);
      logic [PROD_W-1:0]  best_p;
      logic [PROD_W-1:0]  p;
      logic [TOPIC_W-1:0] best_t;
      best_p = '0;
      best_t = TOPIC_FIRST;
      for (int t = 0; t < NUM_TOPICS; t++) begin
         p = PROD_W'(prop_table[{a, TOPIC_W'(t)}]) * PROD_W'(prop_table[{b, TOPIC_W'(t)}]);
         if (t == 0 || p > best_p) begin
            best_p = p;
            best_t = TOPIC_W'(t);
         end
      end
      return best_t;
   endfunction

   // Apply one accepted request to the shadow state; queue a response if the
   // edge clears the cutoff.
   function automatic void predict_request(input eta_req_type r);
      logic [ADDR_W-1:0] addr;
      eta_rsp_type       res;
      if (r.req_type == REQ_LOAD) begin
         addr = {r.row_node, r.topic_index};
         prop_table[addr] = r.propensity;
         if (!entry_written[addr]) begin
            entry_written[addr] = 1'b1;
            node_fill[r.row_node]++;
            if (node_fill[r.row_node] == NUM_TOPICS)
               ready_nodes.push_back(int'(r.row_node));
         end
         load_count++;
      end else if (r.edge_weight > cutoff_mirror) begin
         res.out_row    = r.row_node;
         res.out_col    = r.col_node;
         res.out_topic  = best_topic(r.row_node, r.col_node);
         res.out_weight = r.edge_weight;
         kept_edges_due.push_back(res);
         kept_count++;
      end else begin
         dropped_count++;
      end
   endfunction

   // Unused fields are filled with noise so every bit gets exercised.
   function automatic eta_req_type make_load(input int node, input int topic,
                                             input logic [PROP_W-1:0] v);
      eta_req_type r;
      r.req_type    = REQ_LOAD;
      r.row_node    = NODE_W'(node);
      r.col_node    = NODE_W'($urandom());
      r.topic_index = TOPIC_W'(topic);
      r.propensity  = v;
      r.edge_weight = $urandom();
      return r;
   endfunction

   function automatic eta_req_type make_edge(input int row, input int col,
                                             input logic [WEIGHT_W-1:0] w);
      eta_req_type r;
      r.req_type    = REQ_EDGE;
      r.row_node    = NODE_W'(row);
      r.col_node    = NODE_W'(col);
      r.topic_index = TOPIC_W'($urandom());
      r.propensity  = PROP_W'($urandom());
      r.edge_weight = w;
      return r;
   endfunction

   // Skewed toward tiny and near-max values so ties and big products show up.
   function automatic logic [PROP_W-1:0] random_prop();
      case ($urandom_range(3))
         0:       return PROP_W'($urandom_range(2));
         1:       return 16'hFFFF - PROP_W'($urandom_range(1));
         default: return PROP_W'($urandom());
      endcase
   endfunction

   // Weight relative to the current cutoff: equal, just below, anything, or above.
   function automatic logic [WEIGHT_W-1:0] pick_weight();
      longint unsigned span;
      span = 64'(WEIGHT_MAX) - 64'(cutoff_mirror);
      case ($urandom_range(7))
         0: return cutoff_mirror;
         1: return cutoff_mirror - 1;
         2: return $urandom();
         default: begin
            if (span == 0)
               return $urandom();
            return WEIGHT_W'(64'(cutoff_mirror) + 1 + (64'($urandom()) % span));
         end
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Request driver. Called at a rising edge; leaves req_valid high so that
   // back-to-back requests never lower and raise it in one step. Stall is
   // sampled on the falling edge, where everything has settled.
   // ---------------------------------------------------------------------
   task automatic send_request(input eta_req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= r;
      @(negedge clock);
      while (req_stall)
         @(negedge clock);
      @(posedge clock);
      predict_request(r);
   endtask

   // Sender goes quiet until every queued response arrived, then lets any
   // in-flight dropped edge or load finish.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (kept_edges_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_cutoff(input logic [WEIGHT_W-1:0] v);
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      cutoff_mirror = v;
      cutoff_writes++;
   endtask

   // All topics of one node, in shuffled order.
   task automatic load_node(input int node, input logic [PROP_W-1:0] vals [NUM_TOPICS]);
      int order [$];
      for (int t = 0; t < NUM_TOPICS; t++)
         order.push_back(t);
      order.shuffle();
      foreach (order[i])
         send_request(make_load(node, order[i], vals[order[i]]));
   endtask

   // ---------------------------------------------------------------------
   // Response side: stall generator and checker.
   // ---------------------------------------------------------------------
   int hold_served = 0;
   int hold_left   = 0;

   always @(posedge clock) begin
      if (hold_requests != hold_served) begin
         hold_served <= hold_requests;
         hold_left   <= HOLD_CYCLES;
         rsp_stall   <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Handshake on the coming rising edge is decided by now; compare against
   // the oldest expected response.
   always @(negedge clock) begin : check_rsp
      eta_rsp_type due;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (kept_edges_due.size() == 0) begin
            $error("unexpected response: row %0d col %0d topic %0d weight %h",
                   rsp_item.out_row, rsp_item.out_col, rsp_item.out_topic,
                   rsp_item.out_weight);
            fail_count++;
         end else begin
            due = kept_edges_due.pop_front();
            if (rsp_item.out_row !== due.out_row) begin
               $error("out_row: expected %0d, got %0d", due.out_row, rsp_item.out_row);
               fail_count++;
            end
            if (rsp_item.out_col !== due.out_col) begin
               $error("out_col: expected %0d, got %0d", due.out_col, rsp_item.out_col);
               fail_count++;
            end
            if (rsp_item.out_topic !== due.out_topic) begin
               $error("out_topic: expected %0d, got %0d", due.out_topic, rsp_item.out_topic);
               fail_count++;
            end
            if (rsp_item.out_weight !== due.out_weight) begin
               $error("out_weight: expected %h, got %h", due.out_weight, rsp_item.out_weight);
               fail_count++;
            end
         end
      end
   end

   // Hang detector: any accepted request or response resets the count.
   int quiet_cycles = 0;

   always @(negedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Four hand-built nodes whose ids cover every node bit, then edges over
   // them with the cutoff still at its reset value of zero.
   task automatic test_directed();
      logic [PROP_W-1:0] vals [NUM_TOPICS];
      // node 0: every entry at max -> largest possible product, all equal
      foreach (vals[t]) vals[t] = 16'hFFFF;
      load_node(0, vals);
      // node 1023: all zero -> every product zero
      foreach (vals[t]) vals[t] = 16'h0000;
      load_node(1023, vals);
      // node 341: tied peaks on topics 5 and 9
      foreach (vals[t]) vals[t] = PROP_W'(t + 1);
      vals[5] = 16'h8000;
      vals[9] = 16'h8000;
      load_node(341, vals);
      // node 682: flat with a slight peak on the last topic
      foreach (vals[t]) vals[t] = 16'h0100;
      vals[NUM_TOPICS-1] = 16'h0101;
      load_node(682, vals);

      send_request(make_edge(0, 0, 32'h0));          // weight equals cutoff: dropped
      send_request(make_edge(0, 0, 32'h1));          // all products equal -> topic 0
      send_request(make_edge(1023, 1023, WEIGHT_MAX)); // all zero -> topic 0
      send_request(make_edge(0, 1023, 32'h0001_0000));
      send_request(make_edge(341, 341, 32'h0002_8000)); // tie -> lower topic
      send_request(make_edge(341, 0, 32'hAAAA_5555));
      send_request(make_edge(682, 682, 32'h5555_AAAA)); // winner on last topic
      send_request(make_edge(682, 0, 32'h0000_0002));
      send_request(make_edge(341, 682, 32'h8000_0000));
      send_request(make_edge(682, 341, 32'h7FFF_FFFF));
      wait_drained();
   endtask

   // Cutoff at its maximum and at an edge-equal boundary in the middle.
   task automatic test_cutoff_bounds();
      set_cutoff(WEIGHT_MAX);
      send_request(make_edge(0, 341, WEIGHT_MAX));   // nothing can exceed max
      send_request(make_edge(682, 0, 32'h0));
      set_cutoff(32'h7FFF_FFFF);
      send_request(make_edge(341, 682, 32'h7FFF_FFFF)); // equal: dropped
      send_request(make_edge(341, 682, 32'h8000_0000)); // one above: kept
      send_request(make_edge(0, 682, 32'h7FFF_FFFE));
      send_request(make_edge(1023, 341, WEIGHT_MAX));
      wait_drained();
   endtask

   // Fill a pool of random nodes so random edges have plenty to pick from.
   task automatic test_pool_fill(input int nodes);
      logic [PROP_W-1:0] vals [NUM_TOPICS];
      int n;
      send_idle_pct = 20;
      stall_pct     = 20;
      repeat (nodes) begin
         do n = $urandom_range(MAX_NODES - 1);
         while (node_fill[n] == NUM_TOPICS);
         foreach (vals[t]) vals[t] = random_prop();
         load_node(n, vals);
      end
      wait_drained();
   endtask

   // Receiver holds off for a long stretch while the sender keeps pushing
   // kept edges: the output register and the compute stage fill and the
   // block stalls its request side. Then the sender waits for everything.
   task automatic test_long_hold();
      set_cutoff(32'h0);
      send_idle_pct = 0;
      stall_pct     = 0;
      hold_requests++;
      repeat (24)
         send_request(make_edge(ready_nodes[$urandom_range(ready_nodes.size() - 1)],
                                ready_nodes[$urandom_range(ready_nodes.size() - 1)],
                                $urandom() | 32'h1));
      wait_drained();
   endtask

   // Mostly well-formed traffic: edges over fully loaded nodes, rewrites of
   // loaded entries, and a trickle of loads anywhere in the table.
   task automatic test_random_traffic(input int requests, input int idle_p, input int stall_p);
      int pick;
      send_idle_pct = idle_p;
      stall_pct     = stall_p;
      repeat (requests) begin
         pick = $urandom_range(99);
         if (pick < 70) begin
            send_request(make_edge(ready_nodes[$urandom_range(ready_nodes.size() - 1)],
                                   ready_nodes[$urandom_range(ready_nodes.size() - 1)],
                                   pick_weight()));
         end else if (pick < 90) begin
            send_request(make_load(ready_nodes[$urandom_range(ready_nodes.size() - 1)],
                                   $urandom_range(NUM_TOPICS - 1), random_prop()));
         end else begin
            send_request(make_load($urandom_range(MAX_NODES - 1),
                                   $urandom_range(NUM_TOPICS - 1), random_prop()));
         end
      end
      wait_drained();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_cutoff_bounds();
      test_pool_fill(12);
      test_long_hold();

      set_cutoff(32'h0);
      test_random_traffic(280, 0, 0);
      set_cutoff($urandom());
      test_random_traffic(280, 57, 0);
      set_cutoff(32'h0001_0000);
      test_random_traffic(280, 0, 57);
      set_cutoff($urandom_range(32'h00FF_FFFF));
      test_random_traffic(280, 23, 23);

      wait_drained();
      $display("covered %0d loads, %0d kept edges, %0d dropped edges, %0d cutoff writes",
               load_count, kept_count, dropped_count, cutoff_writes);
      $display("idle/stall phases run with %0d mismatches", fail_count);
      if (fail_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
